[rtl/m61_pkg.sv]
// Shared widths, constants and item types of the Mersenne-61 MAC hash core.
package m61_pkg;

    // Field widths.
    localparam int M61_W     = 61;
    localparam int DATA_W    = 56;
    localparam int HALF_W    = 32;

    // Stream data widths, padded up to whole bytes.
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 64;

    // The Mersenne prime 2^61 - 1.
    localparam logic [M61_W-1:0] M61_P = {M61_W{1'b1}};

    // Command carried in tuser.
    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // One input item as held in the input register.
    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] data;
        logic [M61_W-1:0]  key;
    } t_item;

endpackage

[rtl/m61_mac_core.sv]
// Combinational hash step: ((acc + data) * key) mod 2^61-1, fully reduced.
module m61_mac_core
    import m61_pkg::*;
(
    input  logic [M61_W-1:0]  i_acc,
    input  logic [DATA_W-1:0] i_data,
    input  logic [M61_W-1:0]  i_key,
    output logic [M61_W-1:0]  o_next
);

    logic [M61_W-1:0]          w_key;
    logic [M61_W:0]            w_sum_raw;
    logic [M61_W:0]            w_sum_fold;
    logic [M61_W:0]            w_sum_sub;
    logic [M61_W-1:0]          w_sum;
    logic [HALF_W-1:0]         w_xl;
    logic [M61_W-HALF_W-1:0]   w_xh;
    logic [HALF_W-1:0]         w_yl;
    logic [M61_W-HALF_W-1:0]   w_yh;
    logic [2*HALF_W-1:0]       w_ll;
    logic [M61_W-1:0]          w_lh;
    logic [M61_W-1:0]          w_hl;
    logic [2*(M61_W-HALF_W)-1:0] w_hh;
    logic [2*M61_W-1:0]        w_prod;
    logic [M61_W:0]            w_red;
    logic [M61_W:0]            w_red_sub;

    // A key equal to P is the residue zero.
    assign w_key = (i_key == M61_P) ? '0 : i_key;

    // Add the block; the sum stays below P + 2^56, so one fold and one subtract reduce it.
    assign w_sum_raw  = {1'b0, i_acc} + {{(M61_W + 1 - DATA_W){1'b0}}, i_data};
    assign w_sum_fold = {1'b0, w_sum_raw[M61_W-1:0]} + {{M61_W{1'b0}}, w_sum_raw[M61_W]};
    assign w_sum_sub  = w_sum_fold - {1'b0, M61_P};
    assign w_sum      = (w_sum_fold >= {1'b0, M61_P}) ? w_sum_sub[M61_W-1:0]
                                                      : w_sum_fold[M61_W-1:0];

    // Four partial products of the 61 x 61 multiply, summed into the full product.
    assign w_xl = w_sum[HALF_W-1:0];
    assign w_xh = w_sum[M61_W-1:HALF_W];
    assign w_yl = w_key[HALF_W-1:0];
    assign w_yh = w_key[M61_W-1:HALF_W];

    assign w_ll = w_xl * w_yl;
    assign w_lh = w_xl * w_yh;
    assign w_hl = w_xh * w_yl;
    assign w_hh = w_xh * w_yh;

    assign w_prod = {{(2*M61_W - 2*HALF_W){1'b0}}, w_ll}
                  + ({{M61_W{1'b0}}, w_lh} << HALF_W)
                  + ({{M61_W{1'b0}}, w_hl} << HALF_W)
                  + {w_hh, {(2*HALF_W){1'b0}}};

    // Mersenne fold: the two halves sum below 2P here, so one subtract finishes.
    assign w_red     = {1'b0, w_prod[M61_W-1:0]} + {1'b0, w_prod[2*M61_W-1:M61_W]};
    assign w_red_sub = w_red - {1'b0, M61_P};
    assign o_next    = (w_red >= {1'b0, M61_P}) ? w_red_sub[M61_W-1:0] : w_red[M61_W-1:0];

endmodule

[rtl/mod_mersenne61_mac_hash.sv]
// Top level of the Mersenne-61 polynomial MAC hash core with stream interfaces.
//
// Usage:
//   The slave stream carries one item per transaction. tuser selects absorb (0) or
//   finish (1). On absorb, tdata holds a 56-bit little-endian message block and the
//   61-bit hash key for that block; the accumulator becomes ((acc + block) * key)
//   mod 2^61-1. On finish, tdata holds the message length in bytes and the key;
//   the same step gives the hash, which leaves on the master stream, and the
//   accumulator returns to zero. Absorb items produce no output transaction.
//   Throughput: one item per cycle, except while a finish waits for the output
//   register. Each item passes an input register, then the add, multiply and fold
//   run combinationally against the accumulator register. A finish result
//   passes the input register, then the output register, which it enters when free.
//   When the receiver stalls, the result waits in the output register while
//   absorb items keep flowing; a second finish waits in the input register until
//   the output register frees, and tready stays low while it waits.
//   Reset clears the accumulator and drops all valid flags.
module mod_mersenne61_mac_hash
    import m61_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata fields, lowest bit up: data [55:0], key [116:56], zero pad [119:117]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser fields, lowest bit up: cmd [0]
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata fields, lowest bit up: hash_value [60:0], zero pad [63:61]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_item            r_in;
    t_item            n_in;
    logic             r_in_vld;
    logic             n_in_vld;
    logic [M61_W-1:0] r_acc;
    logic [M61_W-1:0] n_acc;
    logic             r_out_vld;
    logic             n_out_vld;
    logic [M61_W-1:0] r_hash;
    logic [M61_W-1:0] n_hash;
    logic [M61_W-1:0] w_next;
    logic             w_out_free;
    logic             w_adv;
    logic             w_take;
    logic             w_fin;

    // Hash step on the held item.
    m61_mac_core u_core (
        .i_acc  (r_acc),
        .i_data (r_in.data),
        .i_key  (r_in.key),
        .o_next (w_next)
    );

    // Handshake: an absorb always moves on, a finish needs a free output register.
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_fin           = (r_in.cmd == CMD_FINISH);
    assign w_adv           = r_in_vld && (!w_fin || w_out_free);
    assign o_s_axis_tready = !r_in_vld || w_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    // Next values of the input register, accumulator and output register.
    always_comb begin
        n_in_vld  = r_in_vld;
        n_in      = r_in;
        n_acc     = r_acc;
        n_out_vld = r_out_vld;
        n_hash    = r_hash;
        if (w_adv) begin
            n_in_vld = 1'b0;
        end
        if (w_take) begin
            n_in_vld  = 1'b1;
            n_in.cmd  = t_cmd'(i_s_axis_tuser);
            n_in.data = i_s_axis_tdata[DATA_W-1:0];
            n_in.key  = i_s_axis_tdata[DATA_W+M61_W-1:DATA_W];
        end
        if (i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (w_adv) begin
            if (w_fin) begin
                n_acc     = '0;
                n_out_vld = 1'b1;
                n_hash    = w_next;
            end else begin
                n_acc = w_next;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_acc     <= n_acc;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_hash <= n_hash;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(M_TDATA_W-M61_W){1'b0}}, r_hash};

`ifndef SYNTHESIS
    // The accumulator always holds a fully reduced residue.
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc != M61_P)
        else $error("accumulator holds the unreduced value P");

    // A delivered hash is fully reduced.
    a_hash_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_hash != M61_P))
        else $error("hash output holds the unreduced value P");

    // A finish clears the accumulator for the next message.
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_fin) |=> (r_acc == '0))
        else $error("accumulator not cleared after finish");

    // An absorb item never waits on the output side.
    a_absorb_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_fin) |-> w_adv)
        else $error("absorb item stalled in the input register");

    // Reset leaves no result pending.
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_in_vld))
        else $error("valid flag set after reset");
`endif

endmodule

[tb/hash_checker.sv]
// Checker for the Mersenne-61 MAC hash core: predicts every hash and compares results.
module hash_checker
    import m61_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // tdata fields, lowest bit up: data [55:0], key [116:56], zero pad [119:117]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser fields, lowest bit up: cmd [0]
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // tdata fields, lowest bit up: hash_value [60:0], zero pad [63:61]
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_errors,
    output int                   o_pending
);

    // Running polynomial accumulator, always held in 0 .. P-1.
    logic [M61_W-1:0]     mac_acc;
    // Hash words still owed by the core, oldest first, zero padded to the bus width.
    logic [M_TDATA_W-1:0] hash_expect_q[$];

    // One hash step: ((acc + block) * key) mod P, with a key of P acting as zero.
    function automatic logic [M61_W-1:0] poly_step(input logic [M61_W-1:0]  acc,
                                                   input logic [DATA_W-1:0] blk,
                                                   input logic [M61_W-1:0]  key_in);
        logic [127:0]     p_wide;
        logic [127:0]     sum;
        logic [127:0]     prod;
        logic [M61_W-1:0] key_red;
        p_wide  = 128'(M61_P);
        key_red = (key_in == M61_P) ? '0 : key_in;
        sum     = (128'(acc) + 128'(blk)) % p_wide;
        prod    = (sum * 128'(key_red)) % p_wide;
        return prod[M61_W-1:0];
    endfunction

    // Results are matched before new items are predicted; a result can never
    // belong to the item accepted at the same edge.
    always @(posedge i_clk) begin
        logic [M61_W-1:0]     step_val;
        logic [M_TDATA_W-1:0] want;
        if (!i_rst_n) begin
            mac_acc = '0;
            hash_expect_q.delete();
            o_pending = 0;
        end else begin
            // Compare an output transaction with the oldest expected hash.
            if (i_m_tvalid && i_m_tready) begin
                if (hash_expect_q.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: unexpected hash result, actual %h", $time, i_m_tdata);
                end else begin
                    want = hash_expect_q.pop_front();
                    if (i_m_tdata !== want) begin
                        o_errors = o_errors + 1;
                        $display("%0t: hash mismatch, expected %h, actual %h",
                                 $time, want, i_m_tdata);
                    end
                end
            end
            // Advance the model on each input transaction.
            if (i_s_tvalid && i_s_tready) begin
                step_val = poly_step(mac_acc, i_s_tdata[DATA_W-1:0],
                                     i_s_tdata[DATA_W+M61_W-1:DATA_W]);
                if (t_cmd'(i_s_tuser) == CMD_FINISH) begin
                    hash_expect_q.push_back(M_TDATA_W'(step_val));
                    mac_acc = '0;
                end else begin
                    mac_acc = step_val;
                end
            end
            o_pending = hash_expect_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Top of the Mersenne-61 MAC hash testbench: clock, reset, stimulus and verdict.
module tb_top
    import m61_pkg::*;
;

    localparam int TOTAL_ITEMS = 1750;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PAD_W       = S_TDATA_W - M61_W - DATA_W;

    // Idle behavior of either side.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_FULL = 1;
    localparam int IDLE_RARE = 2;

    logic                 clk;
    logic                 rst_n;
    logic                 s_valid;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_data;
    logic                 s_user;
    logic                 m_valid;
    logic                 m_ready;
    logic [M_TDATA_W-1:0] m_data;

    int errors;
    int pending;
    int items_sent;
    int cycle_cnt;
    int tx_mode;
    int rx_mode;
    int hold_req;

    mod_mersenne61_mac_hash uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    hash_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int idle_draw(input int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 16);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Message block with extra weight on the edges of its range.
    function automatic logic [DATA_W-1:0] rand_block();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(0, 255));
            default: return r[DATA_W-1:0];
        endcase
    endfunction

    // Hash key, mostly random, sometimes zero, one, P-1 or the unreduced value P.
    function automatic logic [M61_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return M61_W'(1);
            2:       return M61_P - 1'b1;
            3:       return M61_P;
            default: return r[M61_W-1:0];
        endcase
    endfunction

    // Offer one item after a drawn gap and hold it until the transaction completes.
    task automatic send_item(input t_cmd c, input logic [DATA_W-1:0] d,
                             input logic [M61_W-1:0] k);
        int gap;
        gap = idle_draw(tx_mode);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_data  = {{PAD_W{1'b0}}, k, d};
        s_user  = c;
        s_valid = 1'b1;
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
        s_valid = 1'b0;
        items_sent = items_sent + 1;
    endtask

    // A run of absorbed blocks closed by a finish with the given length.
    task automatic send_message(input int nblk, input logic [DATA_W-1:0] len);
        for (int i = 0; i < nblk; i++)
            send_item(CMD_ABSORB, rand_block(), rand_key());
        send_item(CMD_FINISH, len, rand_key());
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    // Stall the receiver for a long stretch while short messages keep coming.
    task automatic backpressure_burst();
        wait_drained();
        hold_req = 400;
        tx_mode  = IDLE_NONE;
        repeat (20) send_message($urandom_range(0, 1), DATA_W'($urandom_range(0, 14)));
        wait_drained();
    endtask

    // Receiver: after each output transaction it waits a drawn number of cycles;
    // a hold request from the stimulus stalls it for a long stretch.
    initial begin
        int rx_wait;
        int rx_hold;
        rx_wait = 0;
        rx_hold = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req > 0) begin
                rx_hold  = hold_req;
                hold_req = 0;
            end
            if (m_valid && m_ready)
                rx_wait = idle_draw(rx_mode);
            @(negedge clk);
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                m_ready = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int nblk;
        int len;
        bit pressed;
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_user     = 1'b0;
        items_sent = 0;
        cycle_cnt  = 0;
        hold_req   = 0;
        tx_mode    = IDLE_FULL;
        rx_mode    = IDLE_FULL;
        pressed    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Finish with no blocks, at both ends of the length range.
        send_item(CMD_FINISH, '0, rand_key());
        send_item(CMD_FINISH, '1, M61_P - 1'b1);
        // Field extremes.
        send_item(CMD_ABSORB, '0, '0);
        send_item(CMD_ABSORB, '1, M61_P - 1'b1);
        send_item(CMD_ABSORB, '1, M61_P - 1'b1);
        send_item(CMD_FINISH, DATA_W'(21), M61_W'(1));
        // Unreduced key acts as zero, both on absorb and on finish.
        send_item(CMD_ABSORB, rand_block(), M61_P);
        send_item(CMD_FINISH, DATA_W'(7), rand_key());
        send_item(CMD_ABSORB, rand_block(), rand_key());
        send_item(CMD_FINISH, DATA_W'(5), M61_P);
        // Length that does not match the number of blocks.
        repeat (3) send_item(CMD_ABSORB, rand_block(), rand_key());
        send_item(CMD_FINISH, DATA_W'(1000), rand_key());
        send_item(CMD_ABSORB, '1, M61_W'(1));
        send_item(CMD_FINISH, '1, M61_P - 1'b1);

        // Receiver stall with the sender running flat out, then a full pause.
        backpressure_burst();

        // Random part: mostly well-formed messages, some loose items.
        while (items_sent < TOTAL_ITEMS) begin
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            if (!pressed && items_sent > TOTAL_ITEMS / 2) begin
                pressed = 1'b1;
                backpressure_burst();
            end else if ($urandom_range(0, 9) < 8) begin
                nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                   : $urandom_range(0, 4);
                len  = 7 * nblk - $urandom_range(0, 6);
                if (len < 0)
                    len = 0;
                if ($urandom_range(0, 3) == 0)
                    send_message(nblk, rand_block());
                else
                    send_message(nblk, DATA_W'(len));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(t_cmd'($urandom_range(0, 1)), rand_block(), rand_key());
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[mod_mersenne61_mac_hash.f]
rtl/m61_pkg.sv
rtl/m61_mac_core.sv
rtl/mod_mersenne61_mac_hash.sv
tb/hash_checker.sv
tb/tb_top.sv
